>>> rtl/core/record_framer_with_crc32_assert.svh
// assertion macros shared by the record framer checker
// depends on nothing; included by rfcrc_checker.sv
`ifndef RECORD_FRAMER_WITH_CRC32_ASSERT_SVH
`define RECORD_FRAMER_WITH_CRC32_ASSERT_SVH

// same-cycle implication, gated by the active-low reset
`define RFCRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rfcrc assertion failed");

// next-cycle implication, gated by the active-low reset
`define RFCRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rfcrc assertion failed");

`endif

>>> rtl/core/rfcrc_pkg.sv
// package for the record framer: item kinds, sync bytes, crc helpers
// depends on nothing
package rfcrc_pkg;

	typedef enum logic [1:0] {
		KIND_SESSION = 2'd0,
		KIND_BEGIN   = 2'd1,
		KIND_PAYLOAD = 2'd2,
		KIND_END     = 2'd3
	} kind_t;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [7:0]  SYNC_A0  = 8'hAA;
	localparam logic [7:0]  SYNC_A1  = 8'h55;
	localparam logic [7:0]  SYNC_B0  = 8'hA5;
	localparam logic [7:0]  SYNC_B1  = 8'h5A;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} item_t;

	// fold one byte into a crc kept in finalized (inverted) form
	function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = ~crc;
		c = c ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return ~c;
	endfunction

	// header byte at a given beat position
	function automatic logic [7:0] hdr_byte(input logic [2:0] pos, input logic [31:0] cnt);
		logic [7:0] r;
		case (pos)
			3'd0: r = SYNC_A0;
			3'd1: r = SYNC_A1;
			3'd2: r = cnt[31:24];
			3'd3: r = cnt[23:16];
			3'd4: r = cnt[15:8];
			3'd5: r = cnt[7:0];
			3'd6: r = SYNC_B0;
			3'd7: r = SYNC_B1;
			default: r = SYNC_A0;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/rfcrc_in_reg.sv
// input register stage of the record framer
// depends on rfcrc_pkg
module rfcrc_in_reg
	import rfcrc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] data_byte,
	input  logic       take,
	output logic       valid_s1,
	output item_t      item_s1
);

	logic load;

	// hold the item until the engine has produced all its beats
	assign in_stall = valid_s1 && !take;
	assign load     = in_valid && !in_stall;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.kind <= kind_t'(kind);
			item_s1.data <= data_byte;
		end
	end

endmodule

>>> rtl/core/rfcrc_engine.sv
// beat generator with running crc, frame counter and result register
// depends on rfcrc_pkg
module rfcrc_engine
	import rfcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_on,
	input  logic        valid_s1,
	input  item_t       item_s1,
	output logic        take,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic [31:0] crc_value,
	output logic [31:0] frame_total
);

	logic [31:0] crc_q;
	logic [31:0] count_q;
	logic [2:0]  beat_q;
	logic        out_valid_q;

	logic        out_free;
	logic        emit;
	logic        clr;
	logic        is_last;
	logic [7:0]  byte_d;
	logic        bvalid_d;
	logic [31:0] crc_d;
	logic [31:0] count_d;

	assign out_free = !out_valid_q || !out_stall;

	// decode the held item into one beat
	always_comb begin
		emit     = 1'b0;
		clr      = 1'b0;
		take     = 1'b0;
		is_last  = 1'b1;
		byte_d   = 8'd0;
		bvalid_d = 1'b1;
		crc_d    = crc_q;
		count_d  = count_q;
		if (valid_s1) begin
			if (item_s1.kind == KIND_SESSION) begin
				clr  = 1'b1;
				take = 1'b1;
			end else if (!rec_on) begin
				take = 1'b1;
			end else if (out_free) begin
				emit = 1'b1;
				case (item_s1.kind)
					KIND_BEGIN: begin
						byte_d  = hdr_byte(beat_q, count_q);
						is_last = (beat_q == 3'd7);
						crc_d   = crc_fold(crc_q, byte_d);
					end
					KIND_PAYLOAD: begin
						byte_d = item_s1.data;
						crc_d  = crc_fold(crc_q, byte_d);
					end
					KIND_END: begin
						bvalid_d = 1'b0;
						count_d  = count_q + 32'd1;
					end
					default: begin
						emit = 1'b0;
					end
				endcase
				take = is_last;
			end
		end
	end

	// session state and header beat counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= 32'd0;
			count_q <= 32'd0;
			beat_q  <= 3'd0;
		end else if (clr) begin
			crc_q   <= 32'd0;
			count_q <= 32'd0;
			beat_q  <= 3'd0;
		end else if (emit) begin
			crc_q   <= crc_d;
			count_q <= count_d;
			beat_q  <= (item_s1.kind == KIND_BEGIN && !is_last) ? beat_q + 3'd1 : 3'd0;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte    <= byte_d;
			byte_valid  <= bvalid_d;
			run_last    <= is_last;
			crc_value   <= crc_d;
			frame_total <= count_d;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/core/record_framer_with_crc32.sv
// top level of the record framer with running crc-32
// depends on rfcrc_pkg, rfcrc_in_reg, rfcrc_engine
//
// usage
//   input channel: in_valid / in_stall with kind and data_byte. kind selects
//   session start, frame begin, payload byte or frame end.
//   output channel: out_valid / out_stall with out_byte, byte_valid, run_last,
//   crc_value (finalized crc-32 of the session so far) and frame_total.
//   config channel: cfg_valid / cfg_ready with cfg_data[0] = recording on;
//   cfg_ready is always high, write only while the block is idle.
// item flow
//   an item is captured in the input register, then its results in the result
//   register. payload bytes and frame ends give one result each; a frame
//   begin holds the input register for its eight header beats, one result each.
//   session starts and dropped items give no result.
// reset
//   clears the crc, the frame counter, recording_on and all valid flags.
// stall
//   a stalled result holds its payload; the result register and the input
//   register fill, then in_stall rises until out_stall falls.
module record_framer_with_crc32
	import rfcrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        byte_valid,
	output logic        run_last,
	output logic [31:0] crc_value,
	output logic [31:0] frame_total
);

	logic  rec_on_q;
	logic  valid_s1;
	item_t item_s1;
	logic  take;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_on_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			rec_on_q <= cfg_data;
		end
	end

	// input register
	rfcrc_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.data_byte (data_byte),
		.take      (take),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1)
	);

	// beat engine and result register
	rfcrc_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_on      (rec_on_q),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.take        (take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.run_last    (run_last),
		.crc_value   (crc_value),
		.frame_total (frame_total)
	);

endmodule

>>> rtl/core/rfcrc_checker.sv
// port-level checker for the record framer, bound to the top level
// depends on record_framer_with_crc32_assert.svh and record_framer_with_crc32
`include "record_framer_with_crc32_assert.svh"

module rfcrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        byte_valid,
	input logic        run_last,
	input logic [31:0] crc_value,
	input logic [31:0] frame_total
);

	// a stalled result keeps its byte and crc
	`RFCRC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(crc_value))

	// a frame-end status carries a zero byte and closes its item
	`RFCRC_ASSERT_NOW(a_status_form, clk, arst_n, out_valid && !byte_valid, out_byte == 8'd0 && run_last)

	// header beats follow one another without a gap
	`RFCRC_ASSERT_NEXT(a_hdr_no_gap, clk, arst_n, out_valid && !out_stall && !run_last, out_valid)

	// the frame counter does not move inside a header
	`RFCRC_ASSERT_NEXT(a_hdr_count, clk, arst_n, out_valid && !out_stall && !run_last, frame_total == $past(frame_total))

endmodule

bind record_framer_with_crc32 rfcrc_checker u_rfcrc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_byte    (out_byte),
	.byte_valid  (byte_valid),
	.run_last    (run_last),
	.crc_value   (crc_value),
	.frame_total (frame_total)
);
